@@ rtl/core/gss_pkg.sv @@
// ----------------------------------------------------------------------------
// gss_pkg
// Shared types and constants for the gear shift sequencer.
// ----------------------------------------------------------------------------
package gss_pkg;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SHIFT_LOCKOUT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_UP_DELAY      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DOWN_DELAY    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SOLENOID_ON   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RPM_GATE      = 3'd4;

    // register reset values
    localparam logic [15:0] RST_SHIFT_LOCKOUT = 16'd500;
    localparam logic [15:0] RST_UP_DELAY      = 16'd50;
    localparam logic [15:0] RST_DOWN_DELAY    = 16'd100;
    localparam logic [15:0] RST_SOLENOID_ON   = 16'd80;
    localparam logic [15:0] RST_RPM_GATE      = 16'd500;

    // item kinds
    localparam logic OP_TICK    = 1'b0;
    localparam logic OP_REQUEST = 1'b1;

    localparam logic [2:0] GEAR_NEUTRAL = 3'd0;
    localparam logic [2:0] GEAR_FIRST   = 3'd1;
    localparam logic [2:0] GEAR_SECOND  = 3'd2;

    typedef struct packed {
        logic        op;
        logic        shift_down;
        logic [15:0] engine_rpm;
    } t_in;

    typedef struct packed {
        logic [2:0] gear;
        logic       shift_accepted;
        logic       combustion_cut;
        logic       up_solenoid;
        logic       down_solenoid;
        logic       clutch_held;
    } t_out;

    typedef struct packed {
        logic [15:0] shift_lockout_ms;
        logic [15:0] upshift_delay_ms;
        logic [15:0] downshift_delay_ms;
        logic [15:0] solenoid_on_ms;
        logic [15:0] rpm_gate;
    } t_cfg;

endpackage

@@ rtl/core/gss_state.sv @@
// ----------------------------------------------------------------------------
// gss_state
// Sequencer state and its one-item update: gear, lockout timer, solenoid
// countdowns and drive levels.
// ----------------------------------------------------------------------------
module gss_state #(
    parameter int unsigned TOP_GEAR = 6
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_fire,
    input  gss_pkg::t_in  i_item,
    input  gss_pkg::t_cfg i_cfg,
    output gss_pkg::t_out o_result
);

    logic [2:0]  r_gear,     n_gear;
    logic [15:0] r_since,    n_since;
    logic [15:0] r_on_cd,    n_on_cd;
    logic [16:0] r_off_cd,   n_off_cd;
    logic        r_on_pend,  n_on_pend;
    logic        r_off_pend, n_off_pend;
    logic        r_seq_down, n_seq_down;
    logic        r_up,       n_up;
    logic        r_down,     n_down;
    logic        r_clutch,   n_clutch;

    logic        gate_ok;
    logic        fire_on;
    logic        fire_off;
    logic        accepted;
    logic [15:0] delay;

    always_comb begin
        n_gear     = r_gear;
        n_since    = r_since;
        n_on_cd    = r_on_cd;
        n_off_cd   = r_off_cd;
        n_on_pend  = r_on_pend;
        n_off_pend = r_off_pend;
        n_seq_down = r_seq_down;
        n_up       = r_up;
        n_down     = r_down;
        n_clutch   = r_clutch;
        accepted   = 1'b0;
        gate_ok    = i_item.engine_rpm >= i_cfg.rpm_gate;
        fire_on    = r_on_pend && (r_on_cd <= 16'd1);
        fire_off   = r_off_pend && (r_off_cd <= 17'd1);
        delay      = i_item.shift_down ? i_cfg.downshift_delay_ms : i_cfg.upshift_delay_ms;

        if (i_item.op == gss_pkg::OP_TICK) begin
            if (r_since != 16'hFFFF) begin
                n_since = r_since + 16'd1;
            end
            // on event before off event, so a zero on-time ends with the drive off
            if (r_on_pend) begin
                if (fire_on) begin
                    n_on_pend = 1'b0;
                    n_on_cd   = '0;
                    if (gate_ok) begin
                        if (r_seq_down) n_down = 1'b1;
                        else            n_up   = 1'b1;
                    end
                end else begin
                    n_on_cd = r_on_cd - 16'd1;
                end
            end
            if (r_off_pend) begin
                if (fire_off) begin
                    n_off_pend = 1'b0;
                    n_off_cd   = '0;
                    if (gate_ok) begin
                        if (r_seq_down) n_down = 1'b0;
                        else            n_up   = 1'b0;
                    end
                    if (r_seq_down) begin
                        n_clutch = 1'b0;
                    end
                end else begin
                    n_off_cd = r_off_cd - 17'd1;
                end
            end
        end else if (r_since >= i_cfg.shift_lockout_ms) begin
            accepted = 1'b1;
            n_since  = '0;
            if (i_item.engine_rpm == 16'd0) begin
                n_gear = gss_pkg::GEAR_NEUTRAL;
            end else if (!i_item.shift_down && r_gear == gss_pkg::GEAR_NEUTRAL) begin
                n_gear = gss_pkg::GEAR_SECOND;
            end else if (!i_item.shift_down && r_gear < 3'(TOP_GEAR)) begin
                n_gear = r_gear + 3'd1;
            end else if (i_item.shift_down && r_gear == gss_pkg::GEAR_NEUTRAL) begin
                n_gear = gss_pkg::GEAR_FIRST;
            end else if (i_item.shift_down && r_gear > gss_pkg::GEAR_FIRST) begin
                n_gear = r_gear - 3'd1;
            end
            n_seq_down = i_item.shift_down;
            if (i_item.shift_down) begin
                n_clutch = 1'b1;
            end
            n_on_cd    = delay;
            n_off_cd   = {1'b0, delay} + {1'b0, i_cfg.solenoid_on_ms};
            n_on_pend  = 1'b1;
            n_off_pend = 1'b1;
        end
    end

    always_comb begin
        o_result.gear           = n_gear;
        o_result.shift_accepted = accepted;
        o_result.combustion_cut = accepted;
        o_result.up_solenoid    = n_up;
        o_result.down_solenoid  = n_down;
        o_result.clutch_held    = n_clutch;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gear     <= gss_pkg::GEAR_NEUTRAL;
            r_since    <= '0;
            r_on_cd    <= '0;
            r_off_cd   <= '0;
            r_on_pend  <= 1'b0;
            r_off_pend <= 1'b0;
            r_seq_down <= 1'b0;
            r_up       <= 1'b0;
            r_down     <= 1'b0;
            r_clutch   <= 1'b0;
        end else if (i_fire) begin
            r_gear     <= n_gear;
            r_since    <= n_since;
            r_on_cd    <= n_on_cd;
            r_off_cd   <= n_off_cd;
            r_on_pend  <= n_on_pend;
            r_off_pend <= n_off_pend;
            r_seq_down <= n_seq_down;
            r_up       <= n_up;
            r_down     <= n_down;
            r_clutch   <= n_clutch;
        end
    end

endmodule

@@ rtl/core/gear_shift_sequencer_core.sv @@
// ----------------------------------------------------------------------------
// gear_shift_sequencer_core
// Sequential gearbox shift controller driven by millisecond ticks and shift
// requests.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in) carries one tick or one
//   shift request per transfer, each with the engine rpm. Output channel
//   (o_out_valid / i_out_stall / o_out) returns exactly one result per item,
//   in order: gear, accept/cut flags and solenoid and clutch levels.
//   An item passes through the input register, whose contents feed the state
//   update that writes the result register, from which the result transfers out.
//   Throughput is one item per cycle while the receiver does not stall; the
//   state update is a single pass of narrow adds and compares between the
//   input and result registers.
//   When the receiver stalls, the result register holds its payload and the
//   input register holds one more item; o_in_stall then rises.
//   Configuration writes (i_cfg_we, i_cfg_idx, i_cfg_wdata) take effect the
//   next cycle; write only while no item is in flight. Unknown indexes drop.
//   Synchronous reset clears both stages, loads the register defaults and
//   puts the sequencer in neutral with the lockout window starting over.
// ----------------------------------------------------------------------------
module gear_shift_sequencer_core #(
    parameter int unsigned TOP_GEAR = 6
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  gss_pkg::t_in                        i_in,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output gss_pkg::t_out                       o_out,
    input  logic                                i_cfg_we,
    input  logic [gss_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [gss_pkg::CFG_DATA_W-1:0]      i_cfg_wdata
);

    gss_pkg::t_cfg r_cfg;
    gss_pkg::t_in  r_in;
    logic          r_in_valid;
    gss_pkg::t_out r_out;
    logic          r_out_valid;
    gss_pkg::t_out result;

    logic out_ready;
    logic in_xfer;
    logic fire;

    // result stage can take a new item when empty or being drained
    assign out_ready  = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_in_valid && !out_ready;
    assign in_xfer    = i_in_valid && !o_in_stall;
    assign fire       = r_in_valid && out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.shift_lockout_ms   <= gss_pkg::RST_SHIFT_LOCKOUT;
            r_cfg.upshift_delay_ms   <= gss_pkg::RST_UP_DELAY;
            r_cfg.downshift_delay_ms <= gss_pkg::RST_DOWN_DELAY;
            r_cfg.solenoid_on_ms     <= gss_pkg::RST_SOLENOID_ON;
            r_cfg.rpm_gate           <= gss_pkg::RST_RPM_GATE;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                gss_pkg::CFG_SHIFT_LOCKOUT: r_cfg.shift_lockout_ms   <= i_cfg_wdata;
                gss_pkg::CFG_UP_DELAY:      r_cfg.upshift_delay_ms   <= i_cfg_wdata;
                gss_pkg::CFG_DOWN_DELAY:    r_cfg.downshift_delay_ms <= i_cfg_wdata;
                gss_pkg::CFG_SOLENOID_ON:   r_cfg.solenoid_on_ms     <= i_cfg_wdata;
                gss_pkg::CFG_RPM_GATE:      r_cfg.rpm_gate           <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // input register: load on transfer, empty once its item moves on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_xfer) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in <= i_in;
        end
    end

    // state update for the item in the input register
    gss_state #(
        .TOP_GEAR (TOP_GEAR)
    ) u_state (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_item   (r_in),
        .i_cfg    (r_cfg),
        .o_result (result)
    );

    // result register: hold while stalled, advance otherwise
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ready) begin
            r_out_valid <= fire;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= result;
        end
    end

endmodule

@@ rtl/core/gss_checker.sv @@
// ----------------------------------------------------------------------------
// gss_checker
// Port-level checks for the gear shift sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module gss_checker #(
    parameter int unsigned TOP_GEAR = 6
) (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          o_in_stall,
    input logic          o_out_valid,
    input logic          i_out_stall,
    input gss_pkg::t_out o_out
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(o_out_valid && i_out_stall) && $past(i_rst_n) |-> o_out_valid && $stable(o_out))
        else $error("stalled result changed");

    // the cut pulse goes with an accepted shift and nothing else
    a_cut_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out.combustion_cut == o_out.shift_accepted)
        else $error("combustion cut does not match accept");

    // the gear never leaves its range
    a_gear_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out.gear <= 3'(TOP_GEAR))
        else $error("gear out of range");

    // the cycle after a reset edge shows an empty pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("pipeline not empty after reset");

    // a transfer taken while the output is free is never stalled at entry
    a_no_idle_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_out_valid |-> !o_in_stall)
        else $error("input stalled with empty result stage");

endmodule

bind gear_shift_sequencer_core gss_checker #(
    .TOP_GEAR (TOP_GEAR)
) u_gss_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out       (o_out)
);
